// ===== rtl/htmltx_pkg.sv =====
package htmltx_pkg;

  // Lookahead window geometry
  localparam int WinDepth = 9;
  localparam int FillW    = 4;
  localparam int PatW     = 8 * WinDepth;

  typedef logic [WinDepth-1:0][7:0] win_t;
  typedef logic [FillW-1:0]         fill_t;

  // Characters the decision logic looks at or produces
  localparam logic [7:0] ChLess    = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;

  // Patterns, first character in the top byte, padded with zeros
  localparam logic [PatW-1:0] PatScriptOpen  = {"<script", 16'h0};
  localparam logic [PatW-1:0] PatStyleOpen   = {"<style", 24'h0};
  localparam logic [PatW-1:0] PatScriptClose = "</script>";
  localparam logic [PatW-1:0] PatStyleClose  = {"</style>", 8'h0};
  localparam logic [PatW-1:0] PatLt          = {"&lt;", 40'h0};
  localparam logic [PatW-1:0] PatGt          = {"&gt;", 40'h0};
  localparam logic [PatW-1:0] PatAmp         = {"&amp;", 32'h0};
  localparam logic [PatW-1:0] PatQuot        = {"&quot;", 24'h0};
  localparam logic [PatW-1:0] PatNbsp        = {"&nbsp;", 24'h0};

  localparam fill_t LenScriptOpen  = 4'd7;
  localparam fill_t LenStyleOpen   = 4'd6;
  localparam fill_t LenScriptClose = 4'd9;
  localparam fill_t LenStyleClose  = 4'd8;
  localparam fill_t LenLt          = 4'd4;
  localparam fill_t LenGt          = 4'd4;
  localparam fill_t LenAmp         = 4'd5;
  localparam fill_t LenQuot        = 4'd6;
  localparam fill_t LenNbsp        = 4'd6;

  // Compare the head of the window with a pattern; bytes past the fill never match
  function automatic logic win_match(win_t w, fill_t f, logic [PatW-1:0] pat, fill_t len);
    logic ok;
    ok = (f >= len);
    for (int i = 0; i < WinDepth; i++) begin
      if (fill_t'(i) < len && w[i] != pat[PatW-1-8*i -: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Space or one of the control characters tab to carriage return
  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

// ===== rtl/html_readable_text_extractor.sv =====
// HTML text extractor. Takes one byte of a page per transfer and returns
// its readable text: tags, script and style bodies are dropped, five named
// entities are decoded and whitespace runs collapse to one space. Every
// decision is made on the oldest byte of a 9-byte window, so text lags the
// input by 8 bytes; a result passes through the input register and then the
// output register, and out_stall can hold it in between. An ordinary byte
// gives zero or one result with last_of_run set. A byte with end_of_page set
// drains the window from the stored window one byte per cycle while out_stall
// does not hold the output: the push and first decision, up to 8 more
// decisions, then the bare end marker with has_byte low and end_of_document
// high. in_stall stays high until the cycle of the end marker. All state then
// returns to its reset value, so the next byte starts a new page.
module html_readable_text_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] html_byte,
  input  logic       end_of_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] text_byte,
  output logic       has_byte,
  output logic       end_of_document,
  output logic       last_of_run
);
  import htmltx_pkg::*;

  // Input register
  logic       in_vq;
  logic [7:0] in_byte_q;
  logic       in_eop_q;

  // Extraction state
  win_t  win;
  fill_t fill;
  fill_t skip;
  logic  inside_tag;
  logic  inside_script;
  logic  inside_style;
  logic  prev_space;
  logic  pushed;

  // Combinational view
  win_t       wsel;
  fill_t      fsel;
  logic       do_dec;
  logic       marker;
  logic       advance;
  logic       done;
  logic [7:0] c;
  logic [7:0] txt;
  logic       txt_v;
  logic [7:0] emit_c;
  logic       emit_v;
  logic       res_v;
  fill_t      skip_next;
  logic       tag_next;
  logic       script_next;
  logic       style_next;
  logic       prev_next;

  // Window as seen by this cycle: new byte inserted unless already pushed
  always_comb begin
    for (int i = 0; i < WinDepth; i++) begin
      wsel[i] = (!pushed && fill == fill_t'(i)) ? in_byte_q : win[i];
    end
    fsel = pushed ? fill : fill + fill_t'(1);
  end

  assign do_dec  = in_eop_q ? (fsel != '0) : (fsel == fill_t'(WinDepth));
  assign marker  = in_eop_q && (fsel == '0);
  assign done    = !in_eop_q || marker;
  assign advance = in_vq && (!out_valid || !out_stall);
  assign c       = wsel[0];

  // Decide the oldest byte
  always_comb begin
    skip_next   = skip;
    tag_next    = inside_tag;
    script_next = inside_script;
    style_next  = inside_style;
    prev_next   = prev_space;
    txt         = c;
    txt_v       = 1'b0;
    emit_c      = c;
    emit_v      = 1'b0;
    if (skip != '0) begin
      skip_next = skip - fill_t'(1);
    end else if (inside_tag) begin
      if (c == ChGreater) begin
        tag_next = 1'b0;
      end
    end else if (inside_script || inside_style) begin
      if (win_match(wsel, fsel, PatScriptClose, LenScriptClose)) begin
        script_next = 1'b0;
        skip_next   = LenScriptClose - fill_t'(1);
      end else if (win_match(wsel, fsel, PatStyleClose, LenStyleClose)) begin
        style_next = 1'b0;
        skip_next  = LenStyleClose - fill_t'(1);
      end
    end else if (c == ChLess) begin
      tag_next = 1'b1;
      if (win_match(wsel, fsel, PatScriptOpen, LenScriptOpen)) begin
        script_next = 1'b1;
      end
      if (win_match(wsel, fsel, PatStyleOpen, LenStyleOpen)) begin
        style_next = 1'b1;
      end
    end else if (c == ChAmp && win_match(wsel, fsel, PatLt, LenLt)) begin
      txt       = ChLess;
      txt_v     = 1'b1;
      skip_next = LenLt - fill_t'(1);
    end else if (c == ChAmp && win_match(wsel, fsel, PatGt, LenGt)) begin
      txt       = ChGreater;
      txt_v     = 1'b1;
      skip_next = LenGt - fill_t'(1);
    end else if (c == ChAmp && win_match(wsel, fsel, PatAmp, LenAmp)) begin
      txt       = ChAmp;
      txt_v     = 1'b1;
      skip_next = LenAmp - fill_t'(1);
    end else if (c == ChAmp && win_match(wsel, fsel, PatQuot, LenQuot)) begin
      txt       = ChQuote;
      txt_v     = 1'b1;
      skip_next = LenQuot - fill_t'(1);
    end else if (c == ChAmp && win_match(wsel, fsel, PatNbsp, LenNbsp)) begin
      txt       = ChSpace;
      txt_v     = 1'b1;
      skip_next = LenNbsp - fill_t'(1);
    end else begin
      txt_v = 1'b1;
    end

    // Collapse whitespace runs
    if (txt_v) begin
      if (is_space(txt)) begin
        emit_c    = ChSpace;
        emit_v    = !prev_space;
        prev_next = 1'b1;
      end else begin
        emit_c    = txt;
        emit_v    = 1'b1;
        prev_next = 1'b0;
      end
    end
  end

  assign res_v    = do_dec ? emit_v : marker;
  assign in_stall = in_vq && !(advance && done);

  // Input register: hold the item until its last result is produced
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vq <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vq <= 1'b1;
    end else if (advance && done) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_q <= html_byte;
      in_eop_q  <= end_of_page;
    end
  end

  // Advance the window and the parser flags
  always_ff @(posedge clk) begin
    if (rst) begin
      win           <= '0;
      fill          <= '0;
      skip          <= '0;
      inside_tag    <= 1'b0;
      inside_script <= 1'b0;
      inside_style  <= 1'b0;
      prev_space    <= 1'b1;
      pushed        <= 1'b0;
    end else if (advance) begin
      if (marker) begin
        win           <= '0;
        fill          <= '0;
        skip          <= '0;
        inside_tag    <= 1'b0;
        inside_script <= 1'b0;
        inside_style  <= 1'b0;
        prev_space    <= 1'b1;
        pushed        <= 1'b0;
      end else if (do_dec) begin
        for (int i = 0; i < WinDepth - 1; i++) begin
          win[i] <= wsel[i+1];
        end
        win[WinDepth-1] <= '0;
        fill            <= fsel - fill_t'(1);
        skip            <= skip_next;
        inside_tag      <= tag_next;
        inside_script   <= script_next;
        inside_style    <= style_next;
        prev_space      <= prev_next;
        pushed          <= in_eop_q;
      end else begin
        win  <= wsel;
        fill <= fsel;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_v) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_v) begin
      text_byte       <= marker ? 8'h00 : emit_c;
      has_byte        <= !marker;
      end_of_document <= marker;
      last_of_run     <= marker || !in_eop_q;
    end
  end

  // A bare marker always closes the page and the run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> end_of_document && last_of_run)
    else $error("bare result without end of document");

  // Text results never carry the end of document flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> !end_of_document)
    else $error("text result flagged as end of document");

  // The window never rests full
  assert property (@(posedge clk) disable iff (rst)
    fill <= fill_t'(WinDepth - 1))
    else $error("window fill out of range");

  // Draining only happens for a held end of page item
  assert property (@(posedge clk) disable iff (rst)
    pushed |-> in_vq && in_eop_q)
    else $error("drain without an end of page item");

endmodule
